@@ rtl/akcd_pkg.sv @@
// ----------------------------------------------------------------------------
// akcd_pkg
// Types, keyword table and character codes shared by the keyword decoder.
// ----------------------------------------------------------------------------
package akcd_pkg;

  localparam int KW_COUNT    = 11;
  localparam int KW_MAX      = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;

  typedef logic [8*KW_MAX-1:0] kw_str_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // keyword text, right-justified; ids follow the list order
  localparam kw_str_t KW_TEXT [KW_COUNT] = '{
    kw_str_t'("test"),
    kw_str_t'("StartWaving"),
    kw_str_t'("SetSpeed"),
    kw_str_t'("SetThickness"),
    kw_str_t'("SetDrumDirection"),
    kw_str_t'("SetGuideDirection"),
    kw_str_t'("PauseWaving"),
    kw_str_t'("StopWaving"),
    kw_str_t'("ContinueWaving"),
    kw_str_t'("GetHeapInfo"),
    kw_str_t'("GetStackInfo")
  };

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd4, 5'd11, 5'd8, 5'd12, 5'd16, 5'd17, 5'd11, 5'd10, 5'd14, 5'd11, 5'd12
  };

  // end-of-line summary handed from the parser to the resolver
  typedef struct packed {
    logic        value_seen;
    logic        value_negative;
    logic [31:0] magnitude;
    logic        name_ok;
    kw_mask_t    alive;
    logic [4:0]  name_length;
  } line_evt_t;

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [4:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    if (pos < KW_LEN[k]) begin
      ch = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

@@ rtl/akcd_front.sv @@
// ----------------------------------------------------------------------------
// akcd_front
// Byte parser: tracks line grammar, keyword prefixes and the value digits,
// and queues a line summary at a carriage return after a name or value.
// ----------------------------------------------------------------------------
module akcd_front #(
  parameter int LINE_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 evt_push,
  output akcd_pkg::line_evt_t  evt,
  input  logic                 evt_full
);

  localparam int FW = $clog2(LINE_BYTES);
  localparam logic [FW:0] LIMIT = (FW+1)'(LINE_BYTES - 1);

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_NAME   = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_SPACE  = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  logic [FW-1:0]      fill_count, fill_count_next;
  phase_t             phase, phase_next;
  akcd_pkg::kw_mask_t alive, alive_next;
  logic [4:0]         name_length, name_length_next;
  logic               text_ended, text_ended_next;
  logic               value_seen, value_seen_next;
  logic               value_negative, value_negative_next;
  logic [31:0]        acc, acc_next;

  logic               accept;
  logic               is_cr;
  logic [FW:0]        fill_inc;
  akcd_pkg::kw_mask_t name_alive;
  logic [35:0]        acc_mul;
  logic               is_digit;
  logic               is_space;
  logic               is_sign;

  assign in_ready = !evt_full;
  assign accept   = in_valid && in_ready;
  assign is_cr    = (in_byte == akcd_pkg::CH_CR);
  assign fill_inc = {1'b0, fill_count} + (FW+1)'(1);

  assign is_digit = (in_byte >= akcd_pkg::CH_ZERO) && (in_byte <= akcd_pkg::CH_NINE);
  assign is_space = (in_byte == akcd_pkg::CH_SPACE) ||
                    ((in_byte >= akcd_pkg::CH_TAB) && (in_byte <= akcd_pkg::CH_CR));
  assign is_sign  = (in_byte == akcd_pkg::CH_PLUS) || (in_byte == akcd_pkg::CH_MINUS);

  // acc * 10 + digit, as two shifts
  assign acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                   {32'd0, in_byte[3:0] - akcd_pkg::CH_ZERO[3:0]};

  always_comb begin
    for (int k = 0; k < akcd_pkg::KW_COUNT; k++) begin
      name_alive[k] = alive[k] && (akcd_pkg::kw_char(k, name_length) == in_byte);
    end
  end

  always_comb begin
    fill_count_next     = fill_count;
    phase_next          = phase;
    alive_next          = alive;
    name_length_next    = name_length;
    text_ended_next     = text_ended;
    value_seen_next     = value_seen;
    value_negative_next = value_negative;
    acc_next            = acc;
    evt_push            = 1'b0;

    evt.value_seen      = value_seen;
    evt.value_negative  = value_negative;
    evt.magnitude       = acc;
    evt.name_ok         = (phase != PH_LEAD) && (name_length != 5'd0);
    evt.alive           = alive;
    evt.name_length     = name_length;

    if (accept) begin
      if (is_cr) begin
        evt_push = value_seen || evt.name_ok;
      end else begin
        if (in_byte == akcd_pkg::CH_NUL) begin
          text_ended_next = 1'b1;
        end else if (!text_ended) begin
          unique case (phase)
            PH_LEAD, PH_NAME: begin
              if (in_byte == akcd_pkg::CH_EQ) begin
                if (phase == PH_NAME) phase_next = PH_GAP;
              end else begin
                phase_next       = PH_NAME;
                alive_next       = name_alive;
                name_length_next = (name_length == 5'd31) ? name_length
                                                          : name_length + 5'd1;
              end
            end
            PH_GAP, PH_SPACE, PH_DIGITS: begin
              if (phase == PH_GAP && in_byte != akcd_pkg::CH_EQ) begin
                value_seen_next = 1'b1;
              end
              if (in_byte == akcd_pkg::CH_EQ) begin
                if (phase != PH_GAP) phase_next = PH_DONE;
              end else if (phase != PH_DIGITS && is_space) begin
                phase_next = PH_SPACE;
              end else if (phase != PH_DIGITS && is_sign) begin
                phase_next = PH_DIGITS;
                value_negative_next = (in_byte == akcd_pkg::CH_MINUS);
              end else if (is_digit) begin
                phase_next = PH_DIGITS;
                acc_next   = (acc_mul > {4'd0, akcd_pkg::MAG_CAP}) ? akcd_pkg::MAG_CAP
                                                                   : acc_mul[31:0];
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_DONE: begin
            end
            default: begin
            end
          endcase
        end
        fill_count_next = fill_inc[FW-1:0];
      end

      // carriage return or overlong line starts a fresh line
      if (is_cr || fill_inc >= LIMIT) begin
        fill_count_next     = '0;
        phase_next          = PH_LEAD;
        alive_next          = '1;
        name_length_next    = 5'd0;
        text_ended_next     = 1'b0;
        value_seen_next     = 1'b0;
        value_negative_next = 1'b0;
        acc_next            = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      phase          <= PH_LEAD;
      alive          <= '1;
      name_length    <= 5'd0;
      text_ended     <= 1'b0;
      value_seen     <= 1'b0;
      value_negative <= 1'b0;
      acc            <= 32'd0;
    end else begin
      fill_count     <= fill_count_next;
      phase          <= phase_next;
      alive          <= alive_next;
      name_length    <= name_length_next;
      text_ended     <= text_ended_next;
      value_seen     <= value_seen_next;
      value_negative <= value_negative_next;
      acc            <= acc_next;
    end
  end

endmodule

@@ rtl/akcd_queue.sv @@
// ----------------------------------------------------------------------------
// akcd_queue
// Small FIFO of line summaries between the parser and the resolver.
// ----------------------------------------------------------------------------
module akcd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  akcd_pkg::line_evt_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output akcd_pkg::line_evt_t  pop_data,
  output logic                 empty
);

  localparam int AW = akcd_pkg::QUEUE_AW;
  localparam logic [AW:0] DEPTH = (AW+1)'(akcd_pkg::QUEUE_DEPTH);

  akcd_pkg::line_evt_t slots [akcd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == DEPTH);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/akcd_back.sv @@
// ----------------------------------------------------------------------------
// akcd_back
// Line resolver: updates the held value, picks the matching keyword and
// drives the registered result.
// ----------------------------------------------------------------------------
module akcd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_avail,
  input  akcd_pkg::line_evt_t  evt,
  output logic                 evt_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_id,
  output logic signed [31:0]   out_arg
);

  logic [31:0] held;
  logic [31:0] held_next;
  logic        hit;
  logic [3:0]  hit_id;

  assign evt_pop = evt_avail && (!out_valid || out_ready);

  always_comb begin
    held_next = held;
    if (evt.value_seen) begin
      if (evt.value_negative) held_next = 32'd0 - evt.magnitude;
      else if (evt.magnitude > akcd_pkg::POS_MAX) held_next = akcd_pkg::POS_MAX;
      else held_next = evt.magnitude;
    end
  end

  // lowest id wins
  always_comb begin
    hit    = 1'b0;
    hit_id = 4'd0;
    for (int k = akcd_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (evt.name_ok && evt.alive[k] && (evt.name_length == akcd_pkg::KW_LEN[k])) begin
        hit    = 1'b1;
        hit_id = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 32'd0;
      out_valid <= 1'b0;
    end else if (evt_pop) begin
      held      <= held_next;
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop && hit) begin
      out_id  <= hit_id;
      out_arg <= signed'(held_next);
    end
  end

endmodule

@@ rtl/ascii_keyword_command_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ascii_keyword_command_decoder_top
// Line-based ASCII command decoder: keyword and decimal argument per line.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the input stream while the queue has room. A
// carriage return closes a line; a line of the form name=value whose name is
// one of the eleven keywords yields one result item with the keyword id and
// the argument (the value of this line, or the last one given). Unmatched,
// empty and overlong lines yield nothing. The parser keeps up with one byte
// every cycle; each line summary passes through a four-entry queue to the
// resolver, which retires one line per cycle into the output register when
// it is free, so input stalls only when the queue fills while results are
// not being taken. A result is held in a queue slot, then the output register.
module ascii_keyword_command_decoder_top #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [3:0] command_id, [35:4] argument, rest zero
);

  akcd_pkg::line_evt_t push_evt;
  akcd_pkg::line_evt_t pop_evt;
  logic                push;
  logic                full;
  logic                pop;
  logic                empty;
  logic [3:0]          command_id;
  logic signed [31:0]  argument;

  akcd_front #(
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .evt_push (push),
    .evt      (push_evt),
    .evt_full (full)
  );

  akcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_evt),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_evt),
    .empty     (empty)
  );

  akcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_avail (!empty),
    .evt       (pop_evt),
    .evt_pop   (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_id    (command_id),
    .out_arg   (argument)
  );

  assign m_axis_tdata = {4'd0, argument, command_id};

endmodule
